// File: design/u8d_pkg.sv
// Shared types, constants and helper functions for the UTF-8 stream decoder.
package u8d_pkg;

	// Buffer of bytes of an open sequence plus the byte being added
	localparam int PEND_DEPTH = 4;
	localparam int CNT_W = $clog2(PEND_DEPTH + 1);
	localparam int IDX_W = $clog2(PEND_DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PEND_DEPTH);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);
	localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

	// Code point and bus widths
	localparam int CP_W = 21;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 24;

	localparam logic [CP_W-1:0] ESC_BASE = 21'h00DC00;
	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
	localparam logic [CP_W-1:0] BMP_MAX = 21'h00FFFF;
	localparam logic [CP_W-1:0] RSV_MASK = 21'h00FF00;
	localparam logic [CP_W-1:0] MIN_2B = 21'h000080;
	localparam logic [CP_W-1:0] MIN_3B = 21'h000800;
	localparam logic [CP_W-1:0] MIN_4B = 21'h010000;

	localparam logic [7:0] CONT_LO = 8'h80;
	localparam logic [7:0] LEAD2_LO = 8'hC0;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD_END = 8'hF5;

	// Length class of an open sequence
	localparam logic [1:0] LEN_NONE = 2'd0;
	localparam logic [1:0] LEN_2B = 2'd1;
	localparam logic [1:0] LEN_3B = 2'd2;
	localparam logic [1:0] LEN_4B = 2'd3;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_CONT,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_BAD
	} u8d_class_t;

	typedef struct packed {
		logic [7:0] data;
		logic end_mark;
		u8d_class_t cls;
	} u8d_item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic valid;
		u8d_item_t item;
	} u8d_q_t;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic stream_end;
	} u8d_res_t;

	typedef enum logic [1:0] {
		BK_READY,
		BK_SCAN,
		BK_DRAIN
	} u8d_bk_state_t;

	typedef enum logic [1:0] {
		BUF_KEEP,
		BUF_DROP1,
		BUF_CLEAR
	} u8d_buf_op_t;

	// Byte class by value range
	function automatic u8d_class_t classify(input logic [7:0] b);
		u8d_class_t c;
		if (b < CONT_LO) begin
			c = CLS_ASCII;
		end else if (b < LEAD2_LO) begin
			c = CLS_CONT;
		end else if (b < LEAD3_LO) begin
			c = CLS_LEAD2;
		end else if (b < LEAD4_LO) begin
			c = CLS_LEAD3;
		end else if (b < LEAD_END) begin
			c = CLS_LEAD4;
		end else begin
			c = CLS_BAD;
		end
		return c;
	endfunction

	// Smallest legal value for a length class
	function automatic logic [CP_W-1:0] min_for_len(input logic [1:0] len);
		logic [CP_W-1:0] m;
		case (len)
			LEN_2B: m = MIN_2B;
			LEN_3B: m = MIN_3B;
			LEN_4B: m = MIN_4B;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// File: design/utf8_stream_decoder_escaping_top.sv
// Top level of the UTF-8 stream decoder with escaping of invalid bytes.
//
// Input stream (s_*): one transfer per byte; s_tlast=1 marks end of stream and
// its s_tdata byte is ignored. Output stream (m_*): one transfer per code point;
// m_tuser=1 flags the end-of-stream marker (code point zero), m_tlast=1 flags
// the final result caused by one input transfer. An input transfer may cause no
// result (lead or continuation byte) or up to four.
// Configuration (cfg_*): writes the admit-NUL bit; change it only while idle.
// With the sequencer free, the last result of a transfer goes through the input
// queue and then the output register to m_tvalid; earlier results of the same
// transfer wait in a hold register until the next one is found.
// Throughput: one byte per cycle for valid text while the receiver takes results,
// set by the one-byte-per-cycle decode sequencer. A broken sequence makes the
// sequencer rescan each buffered byte after the lead (at most three), with a
// drain step when two results finish together; at end of stream each flushed
// byte is escaped before the marker is sent.
// Reset clears the queue, the open sequence and the admit-NUL bit; no clearing
// pass is needed. When the receiver stalls, the output register holds its
// result, the sequencer stops once it has a result to send, and the two-entry
// input queue keeps taking transfers until it is full.
module utf8_stream_decoder_escaping_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [u8d_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] in_byte
	input  logic                              s_tlast,  // end_mark
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [u8d_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [20:0] code_point, [23:21] zero
	output logic                              m_tuser,  // [0] stream_end
	output logic                              m_tlast,  // last_of_run
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data  // admit_nul
);

	logic admit_nul_q;
	logic pop;
	u8d_pkg::u8d_q_t head;

	// Admit-NUL register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			admit_nul_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			admit_nul_q <= cfg_data;
		end
	end

	u8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.pop      (pop),
		.head     (head)
	);

	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.admit_nul (admit_nul_q),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: design/u8d_front.sv
// Front end: accepts stream transfers, classifies each byte and queues it.
module u8d_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,  // [7:0] in_byte
	input  logic                    s_tlast,
	input  logic                    pop,
	output u8d_pkg::u8d_q_t         head
);

	u8d_pkg::u8d_item_t fifo_q [u8d_pkg::QUEUE_DEPTH];
	logic [u8d_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [u8d_pkg::QCNT_W-1:0] fill_q;
	u8d_pkg::u8d_item_t in_item;
	logic push, deq;

	// Classify on the way in
	always_comb begin
		in_item.data = s_tdata;
		in_item.end_mark = s_tlast;
		in_item.cls = u8d_pkg::classify(s_tdata);
	end

	assign s_tready = (fill_q != u8d_pkg::QCNT_FULL);
	assign push = s_tvalid && s_tready;
	assign deq = pop && (fill_q != '0);

	always_comb begin
		head.valid = (fill_q != '0);
		head.item = fifo_q[rd_ptr_q];
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == u8d_pkg::QPTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == u8d_pkg::QPTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, deq})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: design/u8d_back.sv
// Back end: decode sequencer with pending-byte buffer, rescan and output register.
module u8d_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              admit_nul,
	input  u8d_pkg::u8d_q_t                   head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [u8d_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [20:0] code_point, [23:21] zero
	output logic                              m_tuser,  // [0] stream_end
	output logic                              m_tlast
);

	u8d_pkg::u8d_bk_state_t state_q, state_d;

	// Sequencer state
	logic [7:0] pb_q [u8d_pkg::PEND_DEPTH];
	logic [u8d_pkg::CNT_W-1:0] cnt_q, idx_q;
	logic [1:0] br_q, sl_q;
	logic [u8d_pkg::CP_W-1:0] acc_q;
	logic end_q;

	// One result held back until it is known whether it ends the item
	logic hold_vld_q;
	u8d_pkg::u8d_res_t hold_q;

	// Output register
	logic out_vld_q, out_last_q;
	u8d_pkg::u8d_res_t out_q;

	// View of the buffer for this cycle
	logic [7:0] v_pb [u8d_pkg::PEND_DEPTH];
	logic [7:0] nb_pb [u8d_pkg::PEND_DEPTH];
	logic [u8d_pkg::CNT_W-1:0] v_cnt;
	logic v_end;
	logic [7:0] cur_byte;
	u8d_pkg::u8d_class_t cur_cls;

	// Step results
	logic r_vld;
	u8d_pkg::u8d_res_t r_res;
	u8d_pkg::u8d_buf_op_t op;
	logic [u8d_pkg::CNT_W-1:0] n_idx, n_cnt;
	logic [1:0] n_br, n_sl;
	logic [u8d_pkg::CP_W-1:0] n_acc, acc_ext, cur_ext, head_ext;
	logic seq_bad, scan_fin, item_done;

	// Handshake control
	logic active, out_free, push_need, push_last, hold_load, hold_clr, go, adv;
	u8d_pkg::u8d_res_t push_res;

	// Build the working view: in READY the new byte is appended after the pending bytes
	always_comb begin
		v_pb = pb_q;
		v_cnt = cnt_q;
		v_end = end_q;
		cur_byte = pb_q[idx_q[u8d_pkg::IDX_W-1:0]];
		cur_cls = u8d_pkg::classify(cur_byte);
		if (state_q == u8d_pkg::BK_READY) begin
			v_end = head.item.end_mark;
			if (!head.item.end_mark) begin
				v_pb[cnt_q[u8d_pkg::IDX_W-1:0]] = head.item.data;
				v_cnt = cnt_q + 1'b1;
				cur_byte = head.item.data;
				cur_cls = head.item.cls;
			end
		end
	end

	assign cur_ext = {{(u8d_pkg::CP_W - 8){1'b0}}, cur_byte};
	assign head_ext = {{(u8d_pkg::CP_W - 8){1'b0}}, v_pb[0]};
	assign acc_ext = {acc_q[u8d_pkg::CP_W-7:0], cur_byte[5:0]};

	// Completed value out of range, overlong or in the escape block
	always_comb begin
		seq_bad = (acc_ext < u8d_pkg::min_for_len(sl_q)) ||
			((acc_ext <= u8d_pkg::BMP_MAX) &&
			((acc_ext & u8d_pkg::RSV_MASK) == u8d_pkg::ESC_BASE)) ||
			(acc_ext > u8d_pkg::CP_MAX);
	end

	// One decode step
	always_comb begin
		r_vld = 1'b0;
		r_res.cp = '0;
		r_res.stream_end = 1'b0;
		op = u8d_pkg::BUF_KEEP;
		n_idx = idx_q;
		n_br = br_q;
		n_sl = sl_q;
		n_acc = acc_q;
		scan_fin = 1'b0;
		if (idx_q < v_cnt) begin
			if (br_q == 2'd0) begin
				case (cur_cls)
					u8d_pkg::CLS_ASCII: begin
						r_vld = 1'b1;
						r_res.cp = (cur_byte == 8'h00 && !admit_nul) ? u8d_pkg::ESC_BASE : cur_ext;
						op = u8d_pkg::BUF_DROP1;
						n_idx = '0;
					end
					u8d_pkg::CLS_LEAD2: begin
						n_br = 2'd1;
						n_sl = u8d_pkg::LEN_2B;
						n_acc = {{(u8d_pkg::CP_W - 5){1'b0}}, cur_byte[4:0]};
						n_idx = idx_q + 1'b1;
					end
					u8d_pkg::CLS_LEAD3: begin
						n_br = 2'd2;
						n_sl = u8d_pkg::LEN_3B;
						n_acc = {{(u8d_pkg::CP_W - 4){1'b0}}, cur_byte[3:0]};
						n_idx = idx_q + 1'b1;
					end
					u8d_pkg::CLS_LEAD4: begin
						n_br = 2'd3;
						n_sl = u8d_pkg::LEN_4B;
						n_acc = {{(u8d_pkg::CP_W - 3){1'b0}}, cur_byte[2:0]};
						n_idx = idx_q + 1'b1;
					end
					default: begin
						// stray continuation or byte that never starts a sequence
						r_vld = 1'b1;
						r_res.cp = u8d_pkg::ESC_BASE | cur_ext;
						op = u8d_pkg::BUF_DROP1;
						n_idx = '0;
					end
				endcase
			end else if (cur_cls == u8d_pkg::CLS_CONT) begin
				n_acc = acc_ext;
				n_br = br_q - 2'd1;
				if (br_q == 2'd1) begin
					r_vld = 1'b1;
					n_idx = '0;
					if (seq_bad) begin
						r_res.cp = u8d_pkg::ESC_BASE | head_ext;
						op = u8d_pkg::BUF_DROP1;
					end else begin
						r_res.cp = acc_ext;
						op = u8d_pkg::BUF_CLEAR;
					end
				end else begin
					n_idx = idx_q + 1'b1;
				end
			end else begin
				// broken sequence: escape the lead, rescan the rest
				r_vld = 1'b1;
				r_res.cp = u8d_pkg::ESC_BASE | head_ext;
				op = u8d_pkg::BUF_DROP1;
				n_idx = '0;
				n_br = 2'd0;
			end
		end else if (v_end && br_q != 2'd0 && v_cnt != '0) begin
			// end of stream inside a sequence: flush the lead
			r_vld = 1'b1;
			r_res.cp = u8d_pkg::ESC_BASE | head_ext;
			op = u8d_pkg::BUF_DROP1;
			n_idx = '0;
			n_br = 2'd0;
		end else begin
			scan_fin = 1'b1;
			if (v_end) begin
				r_vld = 1'b1;
				r_res.stream_end = 1'b1;
				op = u8d_pkg::BUF_CLEAR;
				n_idx = '0;
				n_br = 2'd0;
				n_sl = u8d_pkg::LEN_NONE;
				n_acc = '0;
			end
		end
	end

	// Buffer update and item completion
	always_comb begin
		case (op)
			u8d_pkg::BUF_DROP1: n_cnt = v_cnt - 1'b1;
			u8d_pkg::BUF_CLEAR: n_cnt = '0;
			default: n_cnt = v_cnt;
		endcase
		nb_pb = v_pb;
		if (op == u8d_pkg::BUF_DROP1) begin
			for (int k = 0; k < u8d_pkg::PEND_DEPTH - 1; k++) begin
				nb_pb[k] = v_pb[k + 1];
			end
		end
		if (idx_q < v_cnt) begin
			item_done = !v_end && (n_idx == n_cnt);
		end else begin
			item_done = scan_fin;
		end
	end

	// FSM outputs: result routing through hold and output register
	always_comb begin
		active = 1'b0;
		push_need = 1'b0;
		push_res = hold_q;
		push_last = 1'b0;
		hold_load = 1'b0;
		hold_clr = 1'b0;
		case (state_q)
			u8d_pkg::BK_READY: active = head.valid;
			u8d_pkg::BK_SCAN: active = 1'b1;
			u8d_pkg::BK_DRAIN: begin
				push_need = 1'b1;
				push_last = 1'b1;
				hold_clr = 1'b1;
			end
			default: active = 1'b0;
		endcase
		if (active) begin
			if (r_vld) begin
				if (hold_vld_q) begin
					push_need = 1'b1;
					hold_load = 1'b1;
				end else if (item_done) begin
					push_need = 1'b1;
					push_res = r_res;
					push_last = 1'b1;
				end else begin
					hold_load = 1'b1;
				end
			end else if (item_done && hold_vld_q) begin
				push_need = 1'b1;
				push_last = 1'b1;
				hold_clr = 1'b1;
			end
		end
		out_free = !out_vld_q || m_tready;
		go = active && (!push_need || out_free);
		adv = active ? go : ((state_q == u8d_pkg::BK_DRAIN) && out_free);
		pop = (state_q == u8d_pkg::BK_READY) && head.valid && go;
	end

	// FSM next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			u8d_pkg::BK_READY, u8d_pkg::BK_SCAN: begin
				if (go) begin
					if (!item_done) begin
						state_d = u8d_pkg::BK_SCAN;
					end else if (r_vld && hold_vld_q) begin
						state_d = u8d_pkg::BK_DRAIN;
					end else begin
						state_d = u8d_pkg::BK_READY;
					end
				end
			end
			u8d_pkg::BK_DRAIN: begin
				if (out_free) begin
					state_d = u8d_pkg::BK_READY;
				end
			end
			default: state_d = u8d_pkg::BK_READY;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8d_pkg::BK_READY;
			cnt_q <= '0;
			idx_q <= '0;
			br_q <= 2'd0;
			sl_q <= u8d_pkg::LEN_NONE;
			acc_q <= '0;
			end_q <= 1'b0;
			hold_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (go) begin
				cnt_q <= n_cnt;
				idx_q <= n_idx;
				br_q <= n_br;
				sl_q <= n_sl;
				acc_q <= n_acc;
				end_q <= v_end;
			end
			if (adv) begin
				if (hold_load) begin
					hold_vld_q <= 1'b1;
				end else if (hold_clr) begin
					hold_vld_q <= 1'b0;
				end
			end
			if (adv && push_need) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (go) begin
			pb_q <= nb_pb;
		end
		if (adv && hold_load) begin
			hold_q <= r_res;
		end
		if (adv && push_need) begin
			out_q <= push_res;
			out_last_q <= push_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {{(u8d_pkg::OUT_TDATA_W - u8d_pkg::CP_W){1'b0}}, out_q.cp};
	assign m_tuser = out_q.stream_end;
	assign m_tlast = out_last_q;

`ifndef ASSERT_OFF
	// Between items every buffered byte has been scanned and nothing is held back
	a_ready_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == u8d_pkg::BK_READY |-> (idx_q == cnt_q) && !hold_vld_q)
		else $error("scan index or hold out of step between items");

	// Between items there is room for the incoming byte
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == u8d_pkg::BK_READY |-> cnt_q < u8d_pkg::CNT_FULL)
		else $error("pending buffer full between items");

	// An open sequence always has its lead byte buffered
	a_open_has_lead: assert property (@(posedge clk) disable iff (!arst_n)
		br_q != 2'd0 |-> cnt_q != '0)
		else $error("open sequence without buffered lead");

	// The end marker is the final result of its item and carries no code point
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.stream_end |-> out_last_q && (out_q.cp == '0))
		else $error("end marker not last or not zero");

	// Drain only ever sends out a held result
	a_drain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == u8d_pkg::BK_DRAIN |-> hold_vld_q)
		else $error("drain state without held result");
`endif

endmodule
